@@ sv/vdlw_pkg.sv @@
// Shared types, constants and command codes for the vector display-list writer.
// No dependencies; every module of the block imports this package.
package vdlw_pkg;

    localparam int GLYPH_ENTRIES_DEF = 17;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Command codes carried in the action field.
    typedef enum logic [3:0] {
        ACT_RTSL   = 4'd0,
        ACT_HALT   = 4'd1,
        ACT_CENTRE = 4'd2,
        ACT_STATUS = 4'd3,
        ACT_SCALE  = 4'd4,
        ACT_JSRL   = 4'd5,
        ACT_SVEC   = 4'd6,
        ACT_LVEC   = 4'd7,
        ACT_DIGIT  = 4'd8,
        ACT_BCD    = 4'd9,
        ACT_GLOAD  = 4'd10,
        ACT_PLOAD  = 4'd11
    } t_action;

    // Opcode bytes and masks of the vector-generator instruction set.
    localparam logic [7:0] OP_RTSL    = 8'hC0;
    localparam logic [7:0] OP_HALT    = 8'h20;
    localparam logic [7:0] OP_CNTR_LO = 8'h40;
    localparam logic [7:0] OP_CNTR_HI = 8'h80;
    localparam logic [7:0] OP_STAT    = 8'h60;
    localparam logic [7:0] OP_SCAL    = 8'h70;
    localparam logic [7:0] OP_JSRL    = 8'hA0;
    localparam logic [7:0] MASK_MSB5  = 8'h1F;
    localparam logic [7:0] MASK_NIB   = 8'h0F;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
        logic [7:0]  value_c;
        logic [15:0] dx_word;
        logic [15:0] dy_word;
        logic        option;
        logic        first_byte;
        logic        last_byte;
        logic [4:0]  glyph_index;
        logic [15:0] load_word;
    } t_in;

    typedef struct packed {
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        suppress_out;
        logic        last;
    } t_out;

    // One classified command: up to four bytes ready to be written.
    typedef struct packed {
        logic [15:0]     base;
        logic [3:0][7:0] bytes;
        logic [3:0]      sup;
        logic [1:0]      last_idx;
        logic            swap;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ sv/vector_display_list_writer_top.sv @@
// The first byte of a command passes through the front-end stage register, the job
// queue and the output register; its remaining bytes follow without a gap while the sink keeps up.
// The output port writes one byte per cycle while i_out_stall is low; a command
// yields two or four bytes there, and glyph and pointer loads produce no bytes.
// Reset is synchronous and active low: list pointer, brightness, suppression carry,
// pipeline and queue are cleared; glyph table entries are undefined until loaded.
module vector_display_list_writer_top
    import vdlw_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic   w_push, w_pop;
    t_job   w_job, w_head;
    t_qstat w_qstat;

    vdlw_front #(
        .GLYPH_ENTRIES(GLYPH_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    vdlw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    vdlw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // Reset leaves nothing to deliver and the input open.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // The bytes of one command leave without a gap when the sink keeps up.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a command's bytes");

    // A full queue always has a byte waiting at the output.
    a_full_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |=> o_out_valid)
        else $error("queue full but output idle");
`endif

endmodule

@@ sv/vdlw_front.sv @@
// Front end: accepts commands, updates pointer, brightness, carry and glyph table,
// and builds one job of up to four bytes. Depends on vdlw_pkg.
module vdlw_front
    import vdlw_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_in    i_in_data,
    input  t_qstat i_qstat,
    output logic   o_push,
    output t_job   o_job
);

    localparam int         GW   = $clog2(GLYPH_ENTRIES);
    localparam logic [4:0] NENT = 5'(GLYPH_ENTRIES);

    logic [15:0] r_glyph [GLYPH_ENTRIES];
    logic [15:0] r_rd0, r_rd1;
    logic        r_rd0_ok, r_rd1_ok;

    logic [15:0] r_lp, n_lp;
    logic [7:0]  r_brt, n_brt;
    logic        r_carry, n_carry;
    logic        r_s1_valid, n_s1_valid;
    logic        r_s1_glyph, n_s1_glyph;
    t_job        r_s1, n_s1;

    logic        w_accept;
    t_job        w_new;
    logic        w_new_glyph;
    logic [2:0]  w_count;
    logic [3:0]  w_nib0, w_nib1;
    logic        w_cy0, w_cy1, w_sup0, w_sup1;
    logic [4:0]  w_idx0, w_idx1;
    logic [15:0] w_x, w_y;
    logic [7:0]  w_brt_eff;
    logic [15:0] w_g0, w_g1;

    assign o_in_stall = r_s1_valid && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_valid && !i_qstat.full;

    // Zero suppression: a BCD byte yields two digits, the high one first.
    always_comb begin
        w_nib0 = (i_in_data.action == ACT_BCD) ? i_in_data.value_a[7:4]
                                               : i_in_data.value_a[3:0];
        w_cy0  = (i_in_data.action == ACT_BCD && !i_in_data.first_byte) ? r_carry
                                                                        : i_in_data.option;
        w_sup0 = w_cy0 && (w_nib0 == 4'd0);
        w_idx0 = w_sup0 ? 5'd0 : {1'b0, w_nib0} + 5'd1;
        w_nib1 = i_in_data.value_a[3:0];
        w_cy1  = w_sup0 && !i_in_data.last_byte;
        w_sup1 = w_cy1 && (w_nib1 == 4'd0);
        w_idx1 = w_sup1 ? 5'd0 : {1'b0, w_nib1} + 5'd1;
    end

    // Vector components: a short vector steps by four times its signed operands.
    always_comb begin
        if (i_in_data.action == ACT_SVEC) begin
            w_x = {{6{i_in_data.value_a[7]}}, i_in_data.value_a, 2'b00};
            w_y = {{6{i_in_data.value_b[7]}}, i_in_data.value_b, 2'b00};
        end else begin
            w_x = i_in_data.dx_word;
            w_y = i_in_data.dy_word;
        end
        w_brt_eff = (i_in_data.action == ACT_SVEC && i_in_data.option) ? i_in_data.value_c
                                                                       : r_brt;
    end

    always_comb begin
        w_new          = '0;
        w_new.base     = r_lp;
        w_new.sup      = {4{r_carry}};
        w_new.last_idx = 2'd1;
        w_new_glyph    = 1'b0;
        w_count        = 3'd2;
        unique case (i_in_data.action)
            ACT_RTSL: begin
                w_new.bytes[0] = OP_RTSL;
                w_new.bytes[1] = OP_RTSL;
            end
            ACT_HALT: begin
                w_new.bytes    = {OP_HALT, OP_HALT, OP_CNTR_HI, OP_CNTR_LO};
                w_new.last_idx = 2'd3;
                w_count        = 3'd4;
            end
            ACT_CENTRE: begin
                w_new.bytes[0] = OP_CNTR_LO;
                w_new.bytes[1] = OP_CNTR_HI;
            end
            ACT_STATUS: begin
                w_new.bytes[0] = i_in_data.option ? r_brt : i_in_data.value_b;
                w_new.bytes[1] = i_in_data.value_a | OP_STAT;
            end
            ACT_SCALE: begin
                w_new.bytes[0] = i_in_data.value_b;
                w_new.bytes[1] = i_in_data.value_a | OP_SCAL;
            end
            ACT_JSRL: begin
                // The high byte of the jump word is stored first, one address up.
                w_new.swap     = 1'b1;
                w_new.bytes[0] = ({1'b0, i_in_data.value_a[7:1]} & MASK_NIB) | OP_JSRL;
                w_new.bytes[1] = {i_in_data.value_a[0], i_in_data.value_b[7:1]};
            end
            ACT_SVEC, ACT_LVEC: begin
                w_new.bytes[0] = w_y[7:0];
                w_new.bytes[1] = w_y[15:8] & MASK_MSB5;
                w_new.bytes[2] = w_x[7:0];
                w_new.bytes[3] = ((w_x[15:8] ^ w_brt_eff) & MASK_MSB5) ^ w_brt_eff;
                w_new.last_idx = 2'd3;
                w_count        = 3'd4;
            end
            ACT_DIGIT: begin
                w_new_glyph = 1'b1;
                w_new.sup   = {4{w_sup0}};
            end
            ACT_BCD: begin
                w_new_glyph    = 1'b1;
                w_new.sup      = {w_sup1, w_sup1, w_sup0, w_sup0};
                w_new.last_idx = 2'd3;
                w_count        = 3'd4;
            end
            default: begin
                w_count = 3'd0;
            end
        endcase
    end

    always_comb begin
        n_lp       = r_lp;
        n_brt      = r_brt;
        n_carry    = r_carry;
        n_s1_valid = r_s1_valid && !o_push;
        n_s1       = r_s1;
        n_s1_glyph = r_s1_glyph;
        if (w_accept) begin
            n_s1_valid = (w_count != 3'd0);
            n_s1       = w_new;
            n_s1_glyph = w_new_glyph;
            n_lp       = r_lp + {13'd0, w_count};
            if (i_in_data.action == ACT_PLOAD) begin
                n_lp = i_in_data.load_word;
            end
            if (i_in_data.action == ACT_SVEC && i_in_data.option) begin
                n_brt = i_in_data.value_c;
            end
            if (i_in_data.action == ACT_DIGIT) begin
                n_carry = w_sup0;
            end
            if (i_in_data.action == ACT_BCD) begin
                n_carry = w_sup1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp       <= '0;
            r_brt      <= '0;
            r_carry    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_glyph <= 1'b0;
        end else begin
            r_lp       <= n_lp;
            r_brt      <= n_brt;
            r_carry    <= n_carry;
            r_s1_valid <= n_s1_valid;
            r_s1_glyph <= n_s1_glyph;
        end
        r_s1 <= n_s1;
    end

    // Glyph table: one write port, two registered read ports for the BCD digits.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.action == ACT_GLOAD && i_in_data.glyph_index < NENT) begin
            r_glyph[i_in_data.glyph_index[GW-1:0]] <= i_in_data.load_word;
        end
        if (w_accept) begin
            r_rd0    <= r_glyph[w_idx0[GW-1:0]];
            r_rd1    <= r_glyph[w_idx1[GW-1:0]];
            r_rd0_ok <= (w_idx0 < NENT);
            r_rd1_ok <= (w_idx1 < NENT);
        end
    end

    assign w_g0 = r_rd0_ok ? r_rd0 : 16'h0000;
    assign w_g1 = r_rd1_ok ? r_rd1 : 16'h0000;

    always_comb begin
        o_job = r_s1;
        if (r_s1_glyph) begin
            o_job.bytes = {w_g1, w_g0};
        end
    end

endmodule

@@ sv/vdlw_queue.sv @@
// Short job queue between the front end and the byte writer.
// Depends on vdlw_pkg for the job and status types.
module vdlw_queue
    import vdlw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_qstat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

@@ sv/vdlw_back.sv @@
// Back end: takes the head job and, while the output is not stalled, writes its bytes
// one per cycle into the output register, with the address of each. Depends on vdlw_pkg.
module vdlw_back
    import vdlw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_head,
    input  t_qstat i_qstat,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_out   o_out_data
);

    logic [1:0] r_k, n_k;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;
    logic       w_load, w_last;
    logic [1:0] w_off;

    assign w_load = !i_qstat.empty && (!r_out_valid || !i_out_stall);
    assign w_last = (r_k == i_head.last_idx);
    assign o_pop  = w_load && w_last;
    // A jump word goes high byte first, so its two offsets are swapped.
    assign w_off  = {r_k[1], r_k[0] ^ i_head.swap};

    always_comb begin
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (w_load) begin
            n_k                 = w_last ? 2'd0 : r_k + 2'd1;
            n_out_valid         = 1'b1;
            n_out.write_address = i_head.base + {14'd0, w_off};
            n_out.write_data    = i_head.bytes[r_k];
            n_out.suppress_out  = i_head.sup[r_k];
            n_out.last          = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
